>>> src/stau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stau_pkg
// Shared types and constants of the saturating time arithmetic unit.
// ----------------------------------------------------------------------------
package stau_pkg;

  localparam int SEC_W  = 64;
  localparam int NS_W   = 30;
  localparam int CMD_W  = 4;

  localparam logic [CMD_W-1:0] CMD_ADD      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SUB      = 4'd1;
  localparam logic [CMD_W-1:0] CMD_LT       = 4'd2;
  localparam logic [CMD_W-1:0] CMD_LE       = 4'd3;
  localparam logic [CMD_W-1:0] CMD_GT       = 4'd4;
  localparam logic [CMD_W-1:0] CMD_GE       = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SEC_AWAY = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SEC_TRNC = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MS_AWAY  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_MS_TRNC  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_US_AWAY  = 4'd10;
  localparam logic [CMD_W-1:0] CMD_US_TRNC  = 4'd11;
  localparam logic [CMD_W-1:0] CMD_NS       = 4'd12;

  localparam logic [NS_W-1:0]  NS_PER_SEC = 30'd1000000000;
  localparam logic [NS_W-1:0]  NS_MAX     = 30'd999999999;
  localparam logic [NS_W-1:0]  NS_PER_MS  = 30'd1000000;
  localparam logic [NS_W-1:0]  NS_PER_US  = 30'd1000;

  localparam logic [SEC_W-1:0] SEC_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [SEC_W-1:0] SEC_MIN = 64'h8000_0000_0000_0000;

  // exact reciprocals for x < 2^30: x / d == (x * RECIP) >> SHIFT
  localparam logic [30:0] RECIP_MS = 31'd1125899907;
  localparam logic [30:0] RECIP_US = 31'd1099511628;

  typedef logic [1:0] unit_t;
  localparam unit_t UNIT_SEC = 2'd0;
  localparam unit_t UNIT_MS  = 2'd1;
  localparam unit_t UNIT_US  = 2'd2;
  localparam unit_t UNIT_NS  = 2'd3;

  typedef struct packed {
    logic             is_arith;
    logic             special;
    logic [SEC_W-1:0] special_s;
    logic [NS_W-1:0]  special_n;
    logic [SEC_W-1:0] a_s;
    logic [NS_W-1:0]  a_n;
    logic [SEC_W-1:0] op_bs;
    logic [NS_W-1:0]  op_bn;
    logic             is_conv;
    logic             away;
    unit_t            unit;
    logic [NS_W-1:0]  q;
    logic             flag;
  } front_t;

endpackage
`default_nettype wire

>>> src/stau_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stau_front
// Clamps nanoseconds, decodes the command, compares, prepares the subtract
// operand and divides the fraction by the unit size.
// ----------------------------------------------------------------------------
module stau_front (
  input  wire                           clk,
  input  wire  [stau_pkg::CMD_W-1:0]    cmd,
  input  wire  [stau_pkg::SEC_W-1:0]    a_s,
  input  wire  [stau_pkg::NS_W-1:0]     a_n,
  input  wire  [stau_pkg::SEC_W-1:0]    b_s,
  input  wire  [stau_pkg::NS_W-1:0]     b_n,
  output stau_pkg::front_t              front
);
  import stau_pkg::*;

  front_t          front_next;
  logic [NS_W-1:0] an_c;
  logic [NS_W-1:0] bn_c;
  logic            s_lt;
  logic            s_gt;
  logic            s_eq;
  logic [60:0]     prod;
  logic [30:0]     recip;

  always_comb begin
    an_c = (a_n > NS_MAX) ? NS_MAX : a_n;
    bn_c = (b_n > NS_MAX) ? NS_MAX : b_n;
    s_lt = $signed(a_s) < $signed(b_s);
    s_gt = $signed(b_s) < $signed(a_s);
    s_eq = a_s == b_s;

    front_next           = '0;
    front_next.a_s       = a_s;
    front_next.a_n       = an_c;
    front_next.op_bs     = b_s;
    front_next.op_bn     = bn_c;
    front_next.unit      = UNIT_SEC;

    unique case (cmd) inside
      CMD_ADD: begin
        front_next.is_arith = 1'b1;
      end
      CMD_SUB: begin
        front_next.is_arith = 1'b1;
        if (bn_c != '0) begin
          front_next.op_bs = ~b_s;
          front_next.op_bn = NS_PER_SEC - bn_c;
        end else if (b_s != SEC_MIN) begin
          front_next.op_bs = SEC_W'(0) - b_s;
          front_next.op_bn = '0;
        end else begin
          front_next.special   = 1'b1;
          front_next.special_s = a_s[SEC_W-1] ? {1'b0, a_s[SEC_W-2:0]} : SEC_MAX;
          front_next.special_n = a_s[SEC_W-1] ? an_c : NS_MAX;
        end
      end
      CMD_LT: front_next.flag = s_lt || (s_eq && an_c < bn_c);
      CMD_LE: front_next.flag = s_lt || (s_eq && an_c <= bn_c);
      CMD_GT: front_next.flag = s_gt || (s_eq && an_c > bn_c);
      CMD_GE: front_next.flag = s_gt || (s_eq && an_c >= bn_c);
      CMD_SEC_AWAY, CMD_SEC_TRNC: begin
        front_next.is_conv = 1'b1;
        front_next.unit    = UNIT_SEC;
      end
      CMD_MS_AWAY, CMD_MS_TRNC: begin
        front_next.is_conv = 1'b1;
        front_next.unit    = UNIT_MS;
      end
      CMD_US_AWAY, CMD_US_TRNC: begin
        front_next.is_conv = 1'b1;
        front_next.unit    = UNIT_US;
      end
      CMD_NS: begin
        front_next.is_conv = 1'b1;
        front_next.unit    = UNIT_NS;
      end
      default: ;
    endcase

    front_next.away = (cmd == CMD_SEC_AWAY) || (cmd == CMD_MS_AWAY) ||
                      (cmd == CMD_US_AWAY);

    recip = (front_next.unit == UNIT_MS) ? RECIP_MS : RECIP_US;
    prod  = 61'(an_c) * 61'(recip);

    case (front_next.unit)
      UNIT_SEC: front_next.q = '0;
      UNIT_MS:  front_next.q = NS_W'(prod[60:50]);
      UNIT_US:  front_next.q = NS_W'(prod[60:40]);
      default:  front_next.q = an_c;
    endcase
  end

  always_ff @(posedge clk) begin
    front <= front_next;
  end

endmodule
`default_nettype wire

>>> src/stau_addsub.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stau_addsub
// Saturating seconds/nanoseconds add with carry and overflow rules, then
// one delay stage to line up with the conversion path.
// ----------------------------------------------------------------------------
module stau_addsub (
  input  wire                           clk,
  input  stau_pkg::front_t              front,
  output logic [stau_pkg::SEC_W-1:0]    sum_s,
  output logic [stau_pkg::NS_W-1:0]     sum_n
);
  import stau_pkg::*;

  logic [NS_W:0]    n;
  logic             carry;
  logic [NS_W-1:0]  n_r;
  logic             a_max;
  logic             b_max;
  logic             inc_a;
  logic             inc_b;
  logic [SEC_W-1:0] as1;
  logic [SEC_W-1:0] bs1;
  logic [SEC_W-1:0] s;
  logic             ovf;
  logic [SEC_W-1:0] rs_next;
  logic [NS_W-1:0]  rn_next;
  logic [SEC_W-1:0] rs_mid;
  logic [NS_W-1:0]  rn_mid;

  always_comb begin
    n     = (NS_W+1)'(front.a_n) + (NS_W+1)'(front.op_bn);
    carry = n >= (NS_W+1)'(NS_PER_SEC);
    n_r   = carry ? NS_W'(n - (NS_W+1)'(NS_PER_SEC)) : n[NS_W-1:0];
    a_max = front.a_s == SEC_MAX;
    b_max = front.op_bs == SEC_MAX;
    inc_a = carry && !a_max;
    inc_b = carry && a_max && !b_max;
    as1   = front.a_s + SEC_W'(inc_a);
    bs1   = front.op_bs + SEC_W'(inc_b);
    s     = front.a_s + front.op_bs + SEC_W'(carry);
    ovf   = (as1[SEC_W-1] == bs1[SEC_W-1]) && (s[SEC_W-1] != as1[SEC_W-1]);

    if (!front.is_arith) begin
      rs_next = '0;
      rn_next = '0;
    end else if (front.special) begin
      rs_next = front.special_s;
      rn_next = front.special_n;
    end else if (carry && a_max && b_max) begin
      rs_next = SEC_MAX;
      rn_next = NS_MAX;
    end else if (ovf) begin
      if (!bs1[SEC_W-1] && bs1 != '0) begin
        rs_next = SEC_MAX;
        rn_next = NS_MAX;
      end else begin
        rs_next = SEC_MIN;
        rn_next = '0;
      end
    end else begin
      rs_next = s;
      rn_next = n_r;
    end
  end

  always_ff @(posedge clk) begin
    rs_mid <= rs_next;
    rn_mid <= rn_next;
    sum_s  <= rs_mid;
    sum_n  <= rn_mid;
  end

endmodule
`default_nettype wire

>>> src/stau_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stau_conv
// Conversion of A to a unit count: rounding of the fraction, split 64x30
// product, then the final sum and saturation to 64-bit limits.
// ----------------------------------------------------------------------------
module stau_conv (
  input  wire                           clk,
  input  stau_pkg::front_t              front,
  output logic [stau_pkg::SEC_W-1:0]    conv
);
  import stau_pkg::*;

  logic [NS_W-1:0]   qd_ms;
  logic [NS_W-1:0]   qd_us;
  logic              rem_nz;
  logic              neg;
  logic              inc;
  logic [NS_W:0]     frac_next;
  logic [NS_W-1:0]   units;
  logic signed [31:0] a_hi;
  logic signed [30:0] u_s;
  logic [61:0]       p_lo_next;
  logic signed [62:0] p_hi_next;

  logic [61:0]       p_lo;
  logic [62:0]       p_hi;
  logic [NS_W:0]     frac;
  logic              neg_r;
  logic              is_conv_r;

  logic [95:0]       total;
  logic              ovf;
  logic [SEC_W-1:0]  conv_next;

  always_comb begin
    qd_ms = NS_W'(front.q * NS_PER_MS);
    qd_us = NS_W'(front.q * NS_PER_US);
    case (front.unit)
      UNIT_SEC: begin
        rem_nz = front.a_n != '0;
        units  = NS_W'(1);
      end
      UNIT_MS: begin
        rem_nz = front.a_n != qd_ms;
        units  = NS_W'(1000);
      end
      UNIT_US: begin
        rem_nz = front.a_n != qd_us;
        units  = NS_PER_MS;
      end
      default: begin
        rem_nz = 1'b0;
        units  = NS_PER_SEC;
      end
    endcase
    neg       = front.a_s[SEC_W-1];
    inc       = rem_nz && (front.away ? !neg : neg);
    frac_next = (NS_W+1)'(front.q) + (NS_W+1)'(inc);
    a_hi      = $signed(front.a_s[63:32]);
    u_s       = $signed({1'b0, units});
    p_lo_next = 62'(front.a_s[31:0]) * 62'(units);
    p_hi_next = 63'(a_hi) * 63'(u_s);
  end

  always_ff @(posedge clk) begin
    p_lo      <= p_lo_next;
    p_hi      <= p_hi_next;
    frac      <= frac_next;
    neg_r     <= neg;
    is_conv_r <= front.is_conv;
  end

  always_comb begin
    total = {p_hi[62], p_hi, 32'b0} + {34'b0, p_lo} + {65'b0, frac};
    ovf   = !((&total[95:63]) || !(|total[95:63]));
    if (!is_conv_r) begin
      conv_next = '0;
    end else if (ovf) begin
      conv_next = neg_r ? SEC_MIN : SEC_MAX;
    end else begin
      conv_next = total[SEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    conv <= conv_next;
  end

endmodule
`default_nettype wire

>>> src/saturating_time_arithmetic_unit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// saturating_time_arithmetic_unit_core
// Saturating add/subtract, compare and unit conversion of time values.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers at a rising edge with start high and busy low. busy is
//   always low: the unit takes one item every cycle.
//   Each item gives one result. done is high for exactly one cycle with the
//   result fields; the receiver takes it at the edge that ends that cycle.
//   From the transfer edge to the edge that takes the result, an item passes
//   the input register, the decode/compare/divide stage, the add and split
//   multiply stage and the conversion sum stage into the result register.
//   Throughput is one item per cycle; every stage is a plain register.
//   Fields a command does not produce read as zero; commands 13 to 15 give
//   an all-zero result.
//   Reset (rst, synchronous) clears the valid pipeline, so no result is
//   shown for items in flight. The receiver cannot stall the unit.
// ----------------------------------------------------------------------------
module saturating_time_arithmetic_unit_core (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire  [stau_pkg::CMD_W-1:0]    command,
  input  wire  [stau_pkg::SEC_W-1:0]    a_seconds,
  input  wire  [stau_pkg::NS_W-1:0]     a_nanoseconds,
  input  wire  [stau_pkg::SEC_W-1:0]    b_seconds,
  input  wire  [stau_pkg::NS_W-1:0]     b_nanoseconds,
  output logic                          done,
  output logic [stau_pkg::SEC_W-1:0]    sum_seconds,
  output logic [stau_pkg::NS_W-1:0]     sum_nanoseconds,
  output logic [stau_pkg::SEC_W-1:0]    converted_value,
  output logic                          compare_flag
);
  import stau_pkg::*;

  logic [CMD_W-1:0] cmd_r;
  logic [SEC_W-1:0] a_s_r;
  logic [NS_W-1:0]  a_n_r;
  logic [SEC_W-1:0] b_s_r;
  logic [NS_W-1:0]  b_n_r;
  logic [3:0]       valid;
  logic             flag_mid;
  front_t           front;

  assign busy = 1'b0;
  assign done = valid[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= command;
    a_s_r        <= a_seconds;
    a_n_r        <= a_nanoseconds;
    b_s_r        <= b_seconds;
    b_n_r        <= b_nanoseconds;
    flag_mid     <= front.flag;
    compare_flag <= flag_mid;
  end

  stau_front u_front (
    .clk   (clk),
    .cmd   (cmd_r),
    .a_s   (a_s_r),
    .a_n   (a_n_r),
    .b_s   (b_s_r),
    .b_n   (b_n_r),
    .front (front)
  );

  stau_addsub u_addsub (
    .clk   (clk),
    .front (front),
    .sum_s (sum_seconds),
    .sum_n (sum_nanoseconds)
  );

  stau_conv u_conv (
    .clk   (clk),
    .front (front),
    .conv  (converted_value)
  );

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4))
    else $error("result without a transfer four cycles earlier");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##4 done)
    else $error("transfer did not produce a result");

  a_ns_range: assert property (@(posedge clk) disable iff (rst)
    done |-> sum_nanoseconds <= NS_MAX)
    else $error("nanoseconds out of range");

  a_flag_alone: assert property (@(posedge clk) disable iff (rst)
    (done && compare_flag) |-> (converted_value == '0 && sum_seconds == '0))
    else $error("compare result mixed with other fields");

endmodule
`default_nettype wire
